// ===== src/ctp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctp_pkg
// shared types and constants of the trajectory collision cost block
// ----------------------------------------------------------------------------
package ctp_pkg;

    // item field widths
    localparam int OP_W       = 2;
    localparam int INDEX_W    = 3;
    localparam int RADIUS_W   = 16;
    localparam int COST_W     = 48;
    localparam int HITS_OUT_W = 4;

    // configuration port
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int REG_W   = 3;
    localparam int PEN_W   = 32;

    localparam logic [REG_W-1:0] REG_ENABLE   = 3'd0;
    localparam logic [REG_W-1:0] REG_PENALTY  = 3'd1;
    localparam logic [REG_W-1:0] REG_MARGIN   = 3'd2;
    localparam logic [REG_W-1:0] REG_EGO_RAD  = 3'd3;
    localparam logic [REG_W-1:0] REG_USE_ALL  = 3'd4;

    localparam logic [PEN_W-1:0]    PENALTY_RESET = 32'd256000000;
    localparam logic [RADIUS_W-1:0] MARGIN_RESET  = 16'd100;
    localparam logic [RADIUS_W-1:0] EGO_RAD_RESET = 16'd100;

    // distance arithmetic
    localparam int DIFF_W      = 34;   // holds any difference of two 32-bit coords
    localparam int SQ_IN_W     = 18;   // differences at or above 2^18 never hit
    localparam int SQ_W        = 36;
    localparam int SUM_W       = 37;
    localparam int RAD_W       = 18;   // ego + agent + margin radius
    localparam int AGENT_TAG_W = 5;    // covers up to 32 agents
    localparam int HIT_EXT_W   = 6;
    localparam int PROD_W      = PEN_W + HIT_EXT_W;
    localparam int TOTAL_W     = COST_W + 1;

    localparam logic [HIT_EXT_W-1:0]  HITS_OUT_MAX = 6'd15;
    localparam logic [COST_W-1:0]     COST_MAX     = {COST_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_START  = 2'd0,
        OP_APPEND = 2'd1,
        OP_REMOVE = 2'd2,
        OP_EGO    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AGENT,
        ST_SCAN,
        ST_DRAIN,
        ST_MUL,
        ST_SUM
    } seq_state_t;

    // agent table update from an accepted item
    typedef struct packed {
        logic                valid;
        op_t                 op;
        logic [INDEX_W-1:0]  index;
        logic [RADIUS_W-1:0] radius;
    } tbl_upd_t;

    // one point compare issued to the distance unit
    typedef struct packed {
        logic                   valid;
        logic [AGENT_TAG_W-1:0] agent;
        logic [SQ_W-1:0]        rsq;
    } dist_req_t;

    // compare result leaving the distance unit
    typedef struct packed {
        logic                   valid;
        logic [AGENT_TAG_W-1:0] agent;
    } dist_hit_t;

endpackage

// ===== src/ctp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctp_ram
// generic simple dual port ram, one write port, registered read port
// ----------------------------------------------------------------------------
module ctp_ram #(
    parameter int WIDTH  = 48,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/ctp_agent_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctp_agent_table
// per-agent valid flag, point count and radius, with point store write address
// ----------------------------------------------------------------------------
module ctp_agent_table #(
    parameter int MAX_AGENTS = 8,
    parameter int MAX_POINTS = 32,
    parameter int AGENT_W    = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1,
    parameter int COUNT_W    = $clog2(MAX_POINTS + 1),
    parameter int ADDR_W     = (MAX_AGENTS * MAX_POINTS > 1) ?
                               $clog2(MAX_AGENTS * MAX_POINTS) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ctp_pkg::tbl_upd_t             upd,
    input  logic                          use_all_points,
    input  logic [AGENT_W-1:0]            sel,
    output logic                          sel_valid,
    output logic [COUNT_W-1:0]            sel_count,
    output logic [ctp_pkg::RADIUS_W-1:0]  sel_radius,
    output logic                          wr_en,
    output logic [ADDR_W-1:0]             wr_addr
);

    localparam int SLOT_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    logic                         valid_reg  [MAX_AGENTS];
    logic [COUNT_W-1:0]           count_reg  [MAX_AGENTS];
    logic [ctp_pkg::RADIUS_W-1:0] radius_reg [MAX_AGENTS];

    logic               in_range;
    logic [AGENT_W-1:0] idx;
    logic [COUNT_W-1:0] cur_count;
    logic [COUNT_W-1:0] count_next;
    logic [SLOT_W-1:0]  slot;

    assign in_range  = 32'(upd.index) < 32'(MAX_AGENTS);
    assign idx       = AGENT_W'(upd.index);
    assign cur_count = in_range ? count_reg[idx] : '0;

    // endpoint mode keeps slot 0 only, a full list rewrites its final slot
    always_comb
    begin
        if (!use_all_points)
        begin
            slot       = '0;
            count_next = COUNT_W'(1);
        end
        else if (32'(cur_count) >= 32'(MAX_POINTS))
        begin
            slot       = SLOT_W'(MAX_POINTS - 1);
            count_next = cur_count;
        end
        else
        begin
            slot       = SLOT_W'(cur_count);
            count_next = cur_count + COUNT_W'(1);
        end
    end

    assign wr_en   = upd.valid && in_range && (upd.op == ctp_pkg::OP_APPEND);
    assign wr_addr = ADDR_W'(ADDR_W'(idx) * ADDR_W'(MAX_POINTS)) + ADDR_W'(slot);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_AGENTS; i++)
            begin
                valid_reg[i]  <= 1'b0;
                count_reg[i]  <= '0;
                radius_reg[i] <= '0;
            end
        end
        else if (upd.valid && in_range)
        begin
            case (upd.op)
                ctp_pkg::OP_START:
                begin
                    valid_reg[idx]  <= 1'b1;
                    radius_reg[idx] <= upd.radius;
                    count_reg[idx]  <= '0;
                end
                ctp_pkg::OP_APPEND:
                begin
                    count_reg[idx] <= count_next;
                end
                ctp_pkg::OP_REMOVE:
                begin
                    valid_reg[idx] <= 1'b0;
                    count_reg[idx] <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign sel_valid  = valid_reg[sel];
    assign sel_count  = count_reg[sel];
    assign sel_radius = radius_reg[sel];

endmodule

// ===== src/ctp_dist_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctp_dist_unit
// pipelined squared distance compare of the ego point against one stored point
// ----------------------------------------------------------------------------
module ctp_dist_unit #(
    parameter int COORD_BITS = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ctp_pkg::dist_req_t           req,
    input  logic signed [COORD_BITS-1:0] ego_x,
    input  logic signed [COORD_BITS-1:0] ego_y,
    input  logic [2*COORD_BITS-1:0]      pt_data,
    output ctp_pkg::dist_hit_t           hit,
    output logic                         busy
);

    localparam int DW = ctp_pkg::DIFF_W;
    localparam int QW = ctp_pkg::SQ_IN_W;

    // stage 1: aligned with the registered ram read
    logic                            s1_valid_reg;
    logic [ctp_pkg::AGENT_TAG_W-1:0] s1_agent_reg;
    logic [ctp_pkg::SQ_W-1:0]        s1_rsq_reg;

    // stage 2: absolute differences
    logic                            s2_valid_reg;
    logic [ctp_pkg::AGENT_TAG_W-1:0] s2_agent_reg;
    logic [ctp_pkg::SQ_W-1:0]        s2_rsq_reg;
    logic                            s2_far_reg;
    logic [QW-1:0]                   s2_ax_reg;
    logic [QW-1:0]                   s2_ay_reg;

    // stage 3: squares
    logic                            s3_valid_reg;
    logic [ctp_pkg::AGENT_TAG_W-1:0] s3_agent_reg;
    logic [ctp_pkg::SQ_W-1:0]        s3_rsq_reg;
    logic                            s3_far_reg;
    logic [ctp_pkg::SQ_W-1:0]        s3_sx_reg;
    logic [ctp_pkg::SQ_W-1:0]        s3_sy_reg;

    logic signed [DW-1:0]         dx;
    logic signed [DW-1:0]         dy;
    logic [DW-1:0]                ax;
    logic [DW-1:0]                ay;
    logic                         far;
    logic [ctp_pkg::SUM_W-1:0]    dsq;

    assign dx  = DW'(ego_x) - DW'(signed'(pt_data[COORD_BITS-1:0]));
    assign dy  = DW'(ego_y) - DW'(signed'(pt_data[2*COORD_BITS-1:COORD_BITS]));
    assign ax  = dx[DW-1] ? DW'(-dx) : DW'(dx);
    assign ay  = dy[DW-1] ? DW'(-dy) : DW'(dy);
    assign far = (|ax[DW-1:QW]) || (|ay[DW-1:QW]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= req.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_agent_reg <= req.agent;
        s1_rsq_reg   <= req.rsq;

        s2_agent_reg <= s1_agent_reg;
        s2_rsq_reg   <= s1_rsq_reg;
        s2_far_reg   <= far;
        s2_ax_reg    <= ax[QW-1:0];
        s2_ay_reg    <= ay[QW-1:0];

        s3_agent_reg <= s2_agent_reg;
        s3_rsq_reg   <= s2_rsq_reg;
        s3_far_reg   <= s2_far_reg;
        s3_sx_reg    <= ctp_pkg::SQ_W'(s2_ax_reg) * ctp_pkg::SQ_W'(s2_ax_reg);
        s3_sy_reg    <= ctp_pkg::SQ_W'(s2_ay_reg) * ctp_pkg::SQ_W'(s2_ay_reg);
    end

    assign dsq = ctp_pkg::SUM_W'(s3_sx_reg) + ctp_pkg::SUM_W'(s3_sy_reg);

    assign hit.valid = s3_valid_reg && !s3_far_reg && (dsq < ctp_pkg::SUM_W'(s3_rsq_reg));
    assign hit.agent = s3_agent_reg;
    assign busy      = s1_valid_reg || s2_valid_reg || s3_valid_reg;

endmodule

// ===== src/trajectory_collision_cost_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trajectory_collision_cost_top
// collision cost of ego trajectory samples against stored agent trajectories
// ----------------------------------------------------------------------------
// agent ops (start, append, remove) update the agent table as they are accepted
// ego point: walks all MAX_AGENTS table entries and scans the stored points of live, not yet hit
//   agents, with the single distance compare unit fed one point per cycle, then drains the
//   compare pipeline; an ego point while collision checking is off skips the walk
// last ego point then goes through the cost multiply and saturating add
// one item at a time; a result still waiting in the output register holds the
//   next finished sample, and the input with it, until the result is taken
// reset: agents invalid, counts and hit flags cleared, registers at defaults
// ----------------------------------------------------------------------------
module trajectory_collision_cost_top #(
    parameter int MAX_AGENTS = 8,
    parameter int MAX_POINTS = 32,
    parameter int COORD_BITS = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,

    // item input
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [ctp_pkg::OP_W-1:0]            op,
    input  logic [ctp_pkg::INDEX_W-1:0]         agent_index,
    input  logic [ctp_pkg::RADIUS_W-1:0]        agent_radius_mm,
    input  logic signed [COORD_BITS-1:0]        pos_x,
    input  logic signed [COORD_BITS-1:0]        pos_y,
    input  logic                                last,
    input  logic [ctp_pkg::COST_W-1:0]          base_cost,

    // result output
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ctp_pkg::COST_W-1:0]          total_cost,
    output logic [ctp_pkg::HITS_OUT_W-1:0]      hit_count,

    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ctp_pkg::PADDR_W-1:0]         paddr,
    input  logic [ctp_pkg::PDATA_W-1:0]         pwdata,
    output logic [ctp_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready
);

    localparam int AGENT_W = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;
    localparam int COUNT_W = $clog2(MAX_POINTS + 1);
    localparam int DEPTH   = MAX_AGENTS * MAX_POINTS;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int HCNT_W  = $clog2(MAX_AGENTS + 1);
    localparam int PT_W    = 2 * COORD_BITS;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic                         enable_reg;
    logic [ctp_pkg::PEN_W-1:0]    penalty_reg;
    logic [ctp_pkg::RADIUS_W-1:0] margin_reg;
    logic [ctp_pkg::RADIUS_W-1:0] ego_rad_reg;
    logic                         use_all_reg;
    logic                         cfg_wr;
    logic [ctp_pkg::REG_W-1:0]    cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = paddr[ctp_pkg::PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= 1'b1;
            penalty_reg <= ctp_pkg::PENALTY_RESET;
            margin_reg  <= ctp_pkg::MARGIN_RESET;
            ego_rad_reg <= ctp_pkg::EGO_RAD_RESET;
            use_all_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (cfg_sel)
                ctp_pkg::REG_ENABLE:  enable_reg  <= pwdata[0];
                ctp_pkg::REG_PENALTY: penalty_reg <= pwdata;
                ctp_pkg::REG_MARGIN:  margin_reg  <= pwdata[ctp_pkg::RADIUS_W-1:0];
                ctp_pkg::REG_EGO_RAD: ego_rad_reg <= pwdata[ctp_pkg::RADIUS_W-1:0];
                ctp_pkg::REG_USE_ALL: use_all_reg <= pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (cfg_sel)
            ctp_pkg::REG_ENABLE:  prdata = ctp_pkg::PDATA_W'(enable_reg);
            ctp_pkg::REG_PENALTY: prdata = penalty_reg;
            ctp_pkg::REG_MARGIN:  prdata = ctp_pkg::PDATA_W'(margin_reg);
            ctp_pkg::REG_EGO_RAD: prdata = ctp_pkg::PDATA_W'(ego_rad_reg);
            ctp_pkg::REG_USE_ALL: prdata = ctp_pkg::PDATA_W'(use_all_reg);
            default:              prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer state
    // ------------------------------------------------------------------
    ctp_pkg::seq_state_t state_reg, state_next;

    logic [AGENT_W-1:0]              agent_reg, agent_next;
    logic [COUNT_W-1:0]              point_reg, point_next;
    logic [ctp_pkg::SQ_W-1:0]        rsq_reg, rsq_next;
    logic signed [COORD_BITS-1:0]    ego_x_reg;
    logic signed [COORD_BITS-1:0]    ego_y_reg;
    logic                            last_reg;
    logic [ctp_pkg::COST_W-1:0]      base_reg;
    logic [ctp_pkg::PROD_W-1:0]      prod_reg;

    logic [MAX_AGENTS-1:0]           flags_reg;
    logic [HCNT_W-1:0]               hits_reg;

    logic                            out_valid_reg;
    logic [ctp_pkg::COST_W-1:0]      total_reg;
    logic [ctp_pkg::HITS_OUT_W-1:0]  hit_count_reg;

    logic                            in_acc;
    logic                            is_ego;
    logic                            sample_done;
    logic                            out_free;

    // agent table signals
    ctp_pkg::tbl_upd_t               upd;
    logic                            sel_valid;
    logic [COUNT_W-1:0]              sel_count;
    logic [ctp_pkg::RADIUS_W-1:0]    sel_radius;
    logic                            tbl_wr_en;
    logic [ADDR_W-1:0]               tbl_wr_addr;

    // point store and distance unit signals
    ctp_pkg::dist_req_t              req;
    ctp_pkg::dist_hit_t              hit;
    logic                            dist_busy;
    logic [ADDR_W-1:0]               rd_addr;
    logic [PT_W-1:0]                 rd_data;

    logic                            agent_live;
    logic                            last_agent;
    logic [ctp_pkg::RAD_W-1:0]       r_sum;
    logic [ctp_pkg::HIT_EXT_W-1:0]   hits_eff;
    logic [ctp_pkg::TOTAL_W-1:0]     total_sum;
    logic [AGENT_W-1:0]              hit_idx;

    assign in_ready = (state_reg == ctp_pkg::ST_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign is_ego   = (op == ctp_pkg::OP_EGO);
    assign out_free = !out_valid_reg || out_ready;

    // agent ops go straight to the table on the accepting edge
    assign upd.valid  = in_acc && !is_ego;
    assign upd.op     = ctp_pkg::op_t'(op);
    assign upd.index  = agent_index;
    assign upd.radius = agent_radius_mm;

    ctp_agent_table #(
        .MAX_AGENTS (MAX_AGENTS),
        .MAX_POINTS (MAX_POINTS),
        .AGENT_W    (AGENT_W),
        .COUNT_W    (COUNT_W),
        .ADDR_W     (ADDR_W)
    ) u_table (
        .clk            (clk),
        .rst_n          (rst_n),
        .upd            (upd),
        .use_all_points (use_all_reg),
        .sel            (agent_reg),
        .sel_valid      (sel_valid),
        .sel_count      (sel_count),
        .sel_radius     (sel_radius),
        .wr_en          (tbl_wr_en),
        .wr_addr        (tbl_wr_addr)
    );

    // point store, one row of MAX_POINTS entries per agent, {y, x}
    ctp_ram #(
        .WIDTH  (PT_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_points (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data ({pos_y, pos_x}),
        .rd_en   (req.valid),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ctp_dist_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .ego_x   (ego_x_reg),
        .ego_y   (ego_y_reg),
        .pt_data (rd_data),
        .hit     (hit),
        .busy    (dist_busy)
    );

    // an agent is scanned only if it is live, has points and has not hit yet
    assign agent_live = sel_valid && !flags_reg[agent_reg] && (sel_count != '0);
    assign last_agent = (agent_reg == AGENT_W'(MAX_AGENTS - 1));
    assign r_sum      = ctp_pkg::RAD_W'(ego_rad_reg) + ctp_pkg::RAD_W'(sel_radius)
                      + ctp_pkg::RAD_W'(margin_reg);

    assign rd_addr = ADDR_W'(ADDR_W'(agent_reg) * ADDR_W'(MAX_POINTS)) + ADDR_W'(point_reg);

    assign req.valid = (state_reg == ctp_pkg::ST_SCAN);
    assign req.agent = ctp_pkg::AGENT_TAG_W'(agent_reg);
    assign req.rsq   = rsq_reg;

    // hit count is forced to zero while collision checking is off
    assign hits_eff    = enable_reg ? ctp_pkg::HIT_EXT_W'(hits_reg) : '0;
    assign total_sum   = ctp_pkg::TOTAL_W'(base_reg) + ctp_pkg::TOTAL_W'(prod_reg);
    assign sample_done = (state_reg == ctp_pkg::ST_SUM) && out_free;

    // next state: walk agents, scanning the points of each live agent, then drain and, for a last sample, the cost
    always_comb
    begin
        state_next = state_reg;
        agent_next = agent_reg;
        point_next = point_reg;
        rsq_next   = rsq_reg;

        case (state_reg)
            ctp_pkg::ST_IDLE:
            begin
                if (in_acc && is_ego)
                begin
                    agent_next = '0;
                    if (enable_reg)
                    begin
                        state_next = ctp_pkg::ST_AGENT;
                    end
                    else if (last)
                    begin
                        state_next = ctp_pkg::ST_MUL;
                    end
                end
            end

            ctp_pkg::ST_AGENT:
            begin
                if (agent_live)
                begin
                    rsq_next   = ctp_pkg::SQ_W'(r_sum) * ctp_pkg::SQ_W'(r_sum);
                    point_next = '0;
                    state_next = ctp_pkg::ST_SCAN;
                end
                else if (last_agent)
                begin
                    state_next = ctp_pkg::ST_DRAIN;
                end
                else
                begin
                    agent_next = agent_reg + AGENT_W'(1);
                end
            end

            ctp_pkg::ST_SCAN:
            begin
                point_next = point_reg + COUNT_W'(1);
                if ((point_reg + COUNT_W'(1)) == sel_count)
                begin
                    if (last_agent)
                    begin
                        state_next = ctp_pkg::ST_DRAIN;
                    end
                    else
                    begin
                        agent_next = agent_reg + AGENT_W'(1);
                        state_next = ctp_pkg::ST_AGENT;
                    end
                end
            end

            ctp_pkg::ST_DRAIN:
            begin
                // wait for the last compares to land in the hit flags
                if (!dist_busy)
                begin
                    state_next = last_reg ? ctp_pkg::ST_MUL : ctp_pkg::ST_IDLE;
                end
            end

            ctp_pkg::ST_MUL:
            begin
                state_next = ctp_pkg::ST_SUM;
            end

            ctp_pkg::ST_SUM:
            begin
                if (out_free)
                begin
                    state_next = ctp_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ctp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ctp_pkg::ST_IDLE;
            agent_reg <= '0;
            point_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            agent_reg <= agent_next;
            point_reg <= point_next;
        end
    end

    // item payload and arithmetic registers
    always_ff @(posedge clk)
    begin
        rsq_reg <= rsq_next;
        if (in_acc && is_ego)
        begin
            ego_x_reg <= pos_x;
            ego_y_reg <= pos_y;
            last_reg  <= last;
            base_reg  <= base_cost;
        end
        if (state_reg == ctp_pkg::ST_MUL)
        begin
            prod_reg <= ctp_pkg::PROD_W'(penalty_reg) * ctp_pkg::PROD_W'(hits_eff);
        end
    end

    // hit flags: an agent counts once per sample, cleared when the sample ends
    assign hit_idx = AGENT_W'(hit.agent);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
            hits_reg  <= '0;
        end
        else if (sample_done)
        begin
            flags_reg <= '0;
            hits_reg  <= '0;
        end
        else if (hit.valid && !flags_reg[hit_idx])
        begin
            flags_reg[hit_idx] <= 1'b1;
            hits_reg           <= hits_reg + HCNT_W'(1);
        end
    end

    // output register, loads a finished sample once the previous one is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (sample_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_done)
        begin
            total_reg     <= total_sum[ctp_pkg::COST_W] ? ctp_pkg::COST_MAX
                                                        : total_sum[ctp_pkg::COST_W-1:0];
            hit_count_reg <= (hits_eff > ctp_pkg::HITS_OUT_MAX)
                           ? ctp_pkg::HITS_OUT_W'(ctp_pkg::HITS_OUT_MAX)
                           : hits_eff[ctp_pkg::HITS_OUT_W-1:0];
        end
    end

    assign out_valid  = out_valid_reg;
    assign total_cost = total_reg;
    assign hit_count  = hit_count_reg;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for trajectory_collision_cost_top: items go in with
// random gaps, results drain with random back-pressure, and every result is
// compared against an in-bench prediction of the agent table and hit flags
// ----------------------------------------------------------------------------
module tb_top;

    import ctp_pkg::*;

    localparam int AGENTS       = 8;
    localparam int POINTS       = 32;
    localparam int COORD_W      = 24;
    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 7;
    localparam int IDLE_PCT     = 37;
    // slowest ego point: table walk plus one compare per stored point plus cost
    localparam int DRAIN_CYCLES = 1 + AGENTS + AGENTS * POINTS + 4 + 2 + 30;
    localparam int CYCLE_LIMIT  = 4000000;
    localparam longint FAR_DIFF = 262144;
    localparam int COORD_MAX    = 8388607;
    localparam int COORD_MIN    = -8388608;

    // ------------------------------------------------------------------------
    // prediction of the agent table, hit flags and sample cost
    // ------------------------------------------------------------------------
    class cost_scoreboard;
        logic signed [COORD_W-1:0] pt_x [AGENTS][POINTS];
        logic signed [COORD_W-1:0] pt_y [AGENTS][POINTS];
        int unsigned               pt_count [AGENTS];
        bit                        live [AGENTS];
        logic [RADIUS_W-1:0]       agent_rad [AGENTS];
        logic [AGENTS-1:0]         hit_flags;

        bit                        cfg_enable;
        logic [PEN_W-1:0]          cfg_penalty;
        logic [RADIUS_W-1:0]       cfg_margin;
        logic [RADIUS_W-1:0]       cfg_ego;
        bit                        cfg_all;

        logic [COST_W-1:0]         want_cost [$];
        logic [HITS_OUT_W-1:0]     want_hits [$];
        int                        errors;

        function new();
            for (int a = 0; a < AGENTS; a++)
            begin
                pt_count[a]  = 0;
                live[a]      = 1'b0;
                agent_rad[a] = '0;
            end
            hit_flags   = '0;
            cfg_enable  = 1'b1;
            cfg_penalty = PENALTY_RESET;
            cfg_margin  = MARGIN_RESET;
            cfg_ego     = EGO_RAD_RESET;
            cfg_all     = 1'b0;
            errors      = 0;
        endfunction

        function void report(string what, longint unsigned want, longint unsigned got);
            errors++;
            if (errors <= 10)
                $display("mismatch %s: expected %0h, got %0h", what, want, got);
        endfunction

        function void set_reg(logic [REG_W-1:0] idx, logic [PDATA_W-1:0] value);
            case (idx)
                REG_ENABLE:  cfg_enable  = value[0];
                REG_PENALTY: cfg_penalty = value[PEN_W-1:0];
                REG_MARGIN:  cfg_margin  = value[RADIUS_W-1:0];
                REG_EGO_RAD: cfg_ego     = value[RADIUS_W-1:0];
                REG_USE_ALL: cfg_all     = value[0];
                default: ;
            endcase
        endfunction

        // squared distance test, far differences rejected up front
        function bit point_in_reach(logic signed [COORD_W-1:0] ex,
                                    logic signed [COORD_W-1:0] ey,
                                    int a, int k, longint reach);
            longint dx;
            longint dy;
            dx = longint'(ex) - longint'(pt_x[a][k]);
            dy = longint'(ey) - longint'(pt_y[a][k]);
            if (dx < 0)
                dx = -dx;
            if (dy < 0)
                dy = -dy;
            if (dx >= FAR_DIFF || dy >= FAR_DIFF)
                return 1'b0;
            return (dx * dx + dy * dy) < (reach * reach);
        endfunction

        function void note_item(op_t code, logic [INDEX_W-1:0] idx,
                                logic [RADIUS_W-1:0] rad,
                                logic signed [COORD_W-1:0] x,
                                logic signed [COORD_W-1:0] y,
                                logic lst, logic [COST_W-1:0] base);
            longint      reach;
            int unsigned hits;
            logic [63:0] total;
            int          a;
            int          k;
            int          slot;
            case (code)
                OP_START:
                begin
                    live[idx]      = 1'b1;
                    agent_rad[idx] = rad;
                    pt_count[idx]  = 0;
                end
                OP_APPEND:
                begin
                    if (!cfg_all)
                    begin
                        slot          = 0;
                        pt_count[idx] = 1;
                    end
                    else if (pt_count[idx] >= POINTS)
                        slot = POINTS - 1;
                    else
                    begin
                        slot          = pt_count[idx];
                        pt_count[idx] = slot + 1;
                    end
                    pt_x[idx][slot] = x;
                    pt_y[idx][slot] = y;
                end
                OP_REMOVE:
                begin
                    live[idx]     = 1'b0;
                    pt_count[idx] = 0;
                end
                default:
                begin
                    if (cfg_enable)
                    begin
                        for (a = 0; a < AGENTS; a++)
                        begin
                            if (live[a] && !hit_flags[a])
                            begin
                                reach = longint'(cfg_ego) + longint'(agent_rad[a])
                                      + longint'(cfg_margin);
                                for (k = 0; k < pt_count[a]; k++)
                                begin
                                    if (point_in_reach(x, y, a, k, reach))
                                    begin
                                        hit_flags[a] = 1'b1;
                                        break;
                                    end
                                end
                            end
                        end
                    end
                    if (lst)
                    begin
                        hits  = cfg_enable ? $countones(hit_flags) : 0;
                        total = 64'(base) + 64'(cfg_penalty) * 64'(hits);
                        if (total > 64'(COST_MAX))
                            total = 64'(COST_MAX);
                        want_cost = {want_cost, total[COST_W-1:0]};
                        want_hits = {want_hits,
                                     (hits > 15) ? 4'd15 : hits[HITS_OUT_W-1:0]};
                        hit_flags = '0;
                    end
                end
            endcase
        endfunction

        function void check_result(logic [COST_W-1:0] cost, logic [HITS_OUT_W-1:0] hits);
            logic [COST_W-1:0]     cost_exp;
            logic [HITS_OUT_W-1:0] hits_exp;
            if (want_cost.size() == 0)
            begin
                report("unexpected result, total_cost", 0, cost);
                return;
            end
            cost_exp = want_cost.pop_front();
            hits_exp = want_hits.pop_front();
            if (cost !== cost_exp)
                report("total_cost", cost_exp, cost);
            if (hits !== hits_exp)
                report("hit_count", hits_exp, hits);
        endfunction

        function int pending();
            return want_cost.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // block hookup, every input starts at a known value
    // ------------------------------------------------------------------------
    logic                       clk             = 1'b0;
    logic                       rst_n           = 1'b0;
    logic                       in_valid        = 1'b0;
    logic                       in_ready;
    op_t                        op              = OP_START;
    logic [INDEX_W-1:0]         agent_index     = '0;
    logic [RADIUS_W-1:0]        agent_radius_mm = '0;
    logic signed [COORD_W-1:0]  pos_x           = '0;
    logic signed [COORD_W-1:0]  pos_y           = '0;
    logic                       last            = 1'b0;
    logic [COST_W-1:0]          base_cost       = '0;
    logic                       out_valid;
    logic                       out_ready       = 1'b0;
    logic [COST_W-1:0]          total_cost;
    logic [HITS_OUT_W-1:0]      hit_count;
    logic                       psel            = 1'b0;
    logic                       penable         = 1'b0;
    logic                       pwrite          = 1'b0;
    logic [PADDR_W-1:0]         paddr           = '0;
    logic [PDATA_W-1:0]         pwdata          = '0;
    logic [PDATA_W-1:0]         prdata;
    logic                       pready;

    // no random idling on either side while set
    bit                         steady          = 1'b0;
    int                         cycle_count     = 0;
    cost_scoreboard             sb;

    trajectory_collision_cost_top #(
        .MAX_AGENTS (AGENTS),
        .MAX_POINTS (POINTS),
        .COORD_BITS (COORD_W)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .op              (op),
        .agent_index     (agent_index),
        .agent_radius_mm (agent_radius_mm),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .last            (last),
        .base_cost       (base_cost),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .total_cost      (total_cost),
        .hit_count       (hit_count),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // result side back-pressure, redrawn every cycle
    always @(posedge clk)
        out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);

    // outputs are read at the edge, before the block's own updates land
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_ready === 1'b1)
            sb.check_result(total_cost, hit_count);
    end

    // hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // drivers, each called just after a rising edge
    // ------------------------------------------------------------------------

    // one item: random gap, then hold valid until the block takes it
    task automatic send(op_t code, int idx, int rad, int x, int y, bit lst,
                        logic [COST_W-1:0] base);
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        sx = x[COORD_W-1:0];
        sy = y[COORD_W-1:0];
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        op              <= code;
        agent_index     <= idx[INDEX_W-1:0];
        agent_radius_mm <= rad[RADIUS_W-1:0];
        pos_x           <= sx;
        pos_y           <= sy;
        last            <= lst;
        base_cost       <= base;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        sb.note_item(code, idx[INDEX_W-1:0], rad[RADIUS_W-1:0], sx, sy, lst, base);
    endtask

    // input stops until every expected result is out, then the block gets
    // time to finish ego points that produce no result
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // register write (setup + access) followed by a read-back of the same register
    task automatic reg_write(logic [REG_W-1:0] idx, logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] mask;
        logic [PDATA_W-1:0] got;
        case (idx)
            REG_ENABLE, REG_USE_ALL: mask = 32'h1;
            REG_PENALTY:             mask = 32'hFFFF_FFFF;
            default:                 mask = 32'hFFFF;
        endcase
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        sb.set_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        psel    <= 1'b1;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if ((got & mask) !== (value & mask))
            sb.report("register read-back", value & mask, got);
    endtask

    task automatic set_config(bit en, logic [PEN_W-1:0] pen, int mar, int ego, bit all);
        drain();
        reg_write(REG_ENABLE, 32'(en));
        reg_write(REG_PENALTY, pen);
        reg_write(REG_MARGIN, PDATA_W'(mar[RADIUS_W-1:0]));
        reg_write(REG_EGO_RAD, PDATA_W'(ego[RADIUS_W-1:0]));
        reg_write(REG_USE_ALL, 32'(all));
    endtask

    // ------------------------------------------------------------------------
    // random value helpers
    // ------------------------------------------------------------------------
    function automatic int any_coord();
        return int'($urandom) >>> (32 - COORD_W);
    endfunction

    // mostly close to the scene center so that hits are common
    function automatic int near_coord(int center);
        longint v;
        if ($urandom_range(19) == 0)
            return any_coord();
        v = longint'(center) + $urandom_range(1200) - 600;
        if (v > COORD_MAX)
            v = COORD_MAX;
        if (v < COORD_MIN)
            v = COORD_MIN;
        return int'(v);
    endfunction

    function automatic int pick_radius();
        if ($urandom_range(9) == 0)
            return $urandom_range(65535);
        return $urandom_range(400);
    endfunction

    function automatic logic [COST_W-1:0] pick_cost();
        case ($urandom_range(9))
            0:       return COST_MAX - COST_W'($urandom_range(4000));
            1, 2:    return COST_W'({$urandom, $urandom});
            default: return COST_W'($urandom_range(1 << 20));
        endcase
    endfunction

    // a scene of agents around a random center, with ego samples walking
    // through it; one agent gets most appends so long lists fill up
    task automatic run_random(int n_items);
        int cx;
        int cy;
        int hot;
        int kind;
        int idx;
        cx  = any_coord();
        cy  = any_coord();
        hot = $urandom_range(AGENTS - 1);
        for (int i = 0; i < n_items; i++)
        begin
            kind = $urandom_range(99);
            idx  = $urandom_range(AGENTS - 1);
            if (kind < 10)
            begin
                if (idx == hot && $urandom_range(3) != 0)
                    idx = (idx + 1) % AGENTS;
                send(OP_START, idx, pick_radius(), any_coord(), any_coord(),
                     1'($urandom_range(1)), pick_cost());
            end
            else if (kind < 40)
            begin
                if ($urandom_range(1) == 1)
                    idx = hot;
                send(OP_APPEND, idx, $urandom_range(65535), near_coord(cx),
                     near_coord(cy), 1'($urandom_range(1)), pick_cost());
            end
            else if (kind < 44)
                send(OP_REMOVE, idx, $urandom_range(65535), any_coord(), any_coord(),
                     1'($urandom_range(1)), pick_cost());
            else
                send(OP_EGO, idx, $urandom_range(65535), near_coord(cx), near_coord(cy),
                     $urandom_range(3) == 0, pick_cost());
        end
        // close any open sample so no hit flag crosses a register change
        send(OP_EGO, 0, 0, near_coord(cx), near_coord(cy), 1'b1, pick_cost());
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset defaults: reach is 200 mm plus the agent radius,
        // and only the newest appended point is kept
        send(OP_START, 0, 50, 0, 0, 1'b1, COST_MAX);        // last ignored on agent ops
        send(OP_APPEND, 0, 0, 1000, 1000, 1'b0, 0);
        send(OP_APPEND, 0, 0, 0, 0, 1'b1, 0);               // endpoint replaces old point
        send(OP_START, 7, 65535, 0, 0, 1'b0, 0);            // agent with no points
        send(OP_EGO, 5, 0, 250, 0, 1'b0, 0);                // exactly on the radius: miss
        send(OP_EGO, 0, 0, 1000, 1000, 1'b1, 48'd1000);     // dropped point: miss
        send(OP_EGO, 0, 0, 249, 0, 1'b1, COST_MAX);         // just inside, cost saturates
        send(OP_APPEND, 7, 0, COORD_MAX, COORD_MIN, 1'b0, 0);
        send(OP_EGO, 0, 0, COORD_MAX - int'(FAR_DIFF), COORD_MIN, 1'b1, 0);
        send(OP_EGO, 0, 0, COORD_MIN, COORD_MAX, 1'b1, 48'h5555_5555_5555);
        send(OP_EGO, 0, 0, COORD_MAX - 65000, COORD_MIN + 1000, 1'b1, 48'hAAAA_AAAA_AAAA);
        // agents changed in the middle of a sample keep their hit flags
        send(OP_START, 1, 0, 0, 0, 1'b0, 0);
        send(OP_APPEND, 1, 0, 10, -10, 1'b0, 0);
        send(OP_EGO, 0, 0, 10, -10, 1'b0, 0);
        send(OP_REMOVE, 1, 0, 0, 0, 1'b0, 0);
        send(OP_START, 0, 0, 0, 0, 1'b0, 0);
        send(OP_EGO, 0, 0, 10, -10, 1'b1, 48'd77);
        send(OP_REMOVE, 7, 0, 0, 0, 1'b1, 0);
        send(OP_REMOVE, 0, 0, 0, 0, 1'b0, 0);
        send(OP_EGO, 0, 0, 0, 0, 1'b1, 0);

        run_random(250);

        // whole trajectories, long lists overflow into the final slot
        set_config(1'b1, PENALTY_RESET, 100, 100, 1'b1);
        run_random(300);

        // disabled: base cost passes straight through
        set_config(1'b0, $urandom, $urandom_range(300), $urandom_range(300), 1'b1);
        run_random(150);

        // largest radii and penalty
        set_config(1'b1, 32'hFFFF_FFFF, 65535, 65535, 1'b1);
        run_random(150);

        // zero clearance and penalty, no idling anywhere
        set_config(1'b1, 32'h0, 0, 0, 1'b0);
        steady = 1'b1;
        run_random(250);
        steady = 1'b0;

        repeat (3)
        begin
            set_config($urandom_range(3) != 0, $urandom,
                       $urandom_range(1) ? $urandom_range(300) : $urandom_range(65535),
                       $urandom_range(1) ? $urandom_range(300) : $urandom_range(65535),
                       1'($urandom_range(1)));
            run_random(200);
        end

        drain();
        if (sb.pending() != 0)
            sb.report("results never produced", sb.pending(), 0);

        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
